// ===== sv/pidl_pkg.sv =====
// Shared types and constants for the positional insert/delete list.
`default_nettype none

package pidl_pkg;

  localparam int CMD_BITS      = 2;
  localparam int POS_BITS      = 6;
  localparam int VALUE_BITS    = 32;
  localparam int STATUS_BITS   = 2;
  localparam int INDEX_BITS    = 5;
  localparam int DEPTH_DEF     = 32;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_WR,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_STATUS
  } state_t;

endpackage

`default_nettype wire

// ===== sv/positional_insert_delete_list.sv =====
// Top level: bounded ordered list in a synchronous memory with insert, delete and dump.
//
//  channel | direction | ports                                          | handshake
//  --------+-----------+------------------------------------------------+-----------------
//  in      | input     | in_command, in_position, in_value              | in_valid/in_stall
//  out     | output    | out_status, out_element_index,                 | out_valid/out_stall
//          |           | out_element_value, out_last                    |
//
// One item at a time. Insert and delete shift the entries from the position
// to the tail: each shifted entry costs one memory read and one write-back
// through the store. A dump reads each element into the read register and
// then presents it. Reset clears count and control; the memory is not
// cleared. A stalled result holds in the output register while the next
// item is already accepted and worked on.
`default_nettype none

module positional_insert_delete_list #(
  parameter int DEPTH     = pidl_pkg::DEPTH_DEF,
  parameter int WORD_BITS = pidl_pkg::WORD_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  [pidl_pkg::CMD_BITS-1:0]        in_command,
  input  wire  [pidl_pkg::POS_BITS-1:0]        in_position,
  input  wire  signed [pidl_pkg::VALUE_BITS-1:0] in_value,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [pidl_pkg::STATUS_BITS-1:0]     out_status,
  output logic [pidl_pkg::INDEX_BITS-1:0]      out_element_index,
  output logic signed [pidl_pkg::VALUE_BITS-1:0] out_element_value,
  output logic                                 out_last
);
  import pidl_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;

  logic signed [WORD_BITS-1:0] elem_mem [DEPTH];

  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [AW-1:0]                 idx_r, idx_nxt;
  logic [POS_BITS-1:0]           pos_r, pos_nxt;
  logic signed [VALUE_BITS-1:0]  val_r, val_nxt;
  status_t                       status_r, status_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [STATUS_BITS-1:0]        out_status_r, out_status_nxt;
  logic [INDEX_BITS-1:0]         out_index_r, out_index_nxt;
  logic signed [VALUE_BITS-1:0]  out_value_r, out_value_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          rd_en, wr_en;
  logic [AW-1:0]                 rd_addr, wr_addr;
  logic signed [WORD_BITS-1:0]   wr_data;
  logic signed [WORD_BITS-1:0]   rd_data_r;

  logic                          out_free;
  logic [CMPW-1:0]               cnt_x, pos_x, in_pos_x, idx_x;
  logic                          last_elem;

  assign out_free  = !out_valid_r || !out_stall;
  assign cnt_x     = CMPW'(count_r);
  assign pos_x     = CMPW'(pos_r);
  assign in_pos_x  = CMPW'(in_position);
  assign idx_x     = CMPW'(idx_r);
  assign last_elem = (idx_x + CMPW'(1)) == cnt_x;

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_element_index = out_index_r;
  assign out_element_value = out_value_r;
  assign out_last          = out_last_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      elem_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= elem_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    rd_en          = 1'b0;
    rd_addr        = idx_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = rd_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pos_nxt   = in_position;
          val_nxt   = in_value;
          state_nxt = S_STATUS;
          unique case (cmd_t'(in_command))
            CMD_INSERT: begin
              if (in_pos_x > cnt_x) begin
                status_nxt = ST_BADPOS;
              end else if (count_r == CW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                idx_nxt   = AW'(count_r);
                state_nxt = (cnt_x > in_pos_x) ? S_INS_RD : S_INS_PUT;
              end
            end
            CMD_DELETE: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (in_pos_x >= cnt_x) begin
                status_nxt = ST_BADPOS;
              end else if ((in_pos_x + CMPW'(1)) < cnt_x) begin
                idx_nxt   = AW'(in_position);
                state_nxt = S_DEL_RD;
              end else begin
                // deleting the tail entry: nothing to shift
                count_nxt  = count_r - CW'(1);
                status_nxt = ST_OK;
              end
            end
            CMD_DUMP: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_DUMP_RD;
              end
            end
            default: begin
              status_nxt = ST_BADPOS;
            end
          endcase
        end
      end

      S_INS_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r - AW'(1);
        state_nxt = S_INS_WR;
      end

      S_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        idx_nxt = idx_r - AW'(1);
        state_nxt = ((idx_x - CMPW'(1)) > pos_x) ? S_INS_RD : S_INS_PUT;
      end

      S_INS_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = AW'(pos_r);
        wr_data    = WORD_BITS'(val_r);
        count_nxt  = count_r + CW'(1);
        status_nxt = ST_OK;
        state_nxt  = S_STATUS;
      end

      S_DEL_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r + AW'(1);
        state_nxt = S_DEL_WR;
      end

      S_DEL_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        idx_nxt = idx_r + AW'(1);
        if ((idx_x + CMPW'(2)) < cnt_x) begin
          state_nxt = S_DEL_RD;
        end else begin
          count_nxt  = count_r - CW'(1);
          status_nxt = ST_OK;
          state_nxt  = S_STATUS;
        end
      end

      S_DUMP_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = S_DUMP_OUT;
      end

      S_DUMP_OUT: begin
        // read data holds in rd_data_r until the output register frees up
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_index_nxt  = INDEX_BITS'(idx_r);
          out_value_nxt  = VALUE_BITS'(rd_data_r);
          out_last_nxt   = last_elem;
          if (last_elem) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_DUMP_RD;
          end
        end
      end

      S_STATUS: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_index_nxt  = '0;
          out_value_nxt  = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
